@@ rtl/integer_to_radix_ascii_assert.svh @@
// ---------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Concurrent check wrappers shared by the conversion modules; they expand
// to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
// condition must never be seen outside reset
`define ITRA_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("itra: forbidden condition seen");
// consequence must hold in the cycle after the antecedent
`define ITRA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itra: expected follow-up missing");
`else
`define ITRA_ASSERT_NEVER(name, clk, rst, expr)
`define ITRA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ rtl/itra_pkg.sv @@
// ---------------------------------------------------------------------------
// itra_pkg
// Shared types, radix codes and character constants of the integer to
// radix ascii converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

   // width of the radix field
   localparam int RADIX_W = 5;

   // supported radix codes
   localparam logic [RADIX_W-1:0] RADIX_CODE_BIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_CODE_OCT = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_CODE_DEC = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_CODE_HEX = 5'd16;

   // fixed characters of prefix and sign
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // digit glyphs, upper case hex
   localparam logic [7:0] DIGIT_GLYPHS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_kind_type;

   // per-item control passed from the front end to the converter
   typedef struct packed {
      radix_kind_type kind;
      logic           negative;
   } conv_meta_type;

   function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
      return DIGIT_GLYPHS[digit];
   endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_radix_ascii.sv @@
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to ascii text in radix 2, 8, 10 or 16.
//
// req channel: one beat per conversion, value and radix in tdata. A radix
// other than 2, 8, 10 or 16 is taken and produces no output.
// rsp channel: one beat per character, most significant digit first, with
// prefix "0x", "0b" or "0" and a leading '-' for negative decimals; tlast
// marks the final character of each conversion.
// Rate: the converter works on one item at a time; for decimal it first runs
// a bit-serial binary to bcd conversion over all VALUE_WIDTH bits. The bcd
// loop and the one-character-per-cycle output, while rsp is ready, set it.
// A two-entry queue lets the input side take items while a conversion runs.
// Reset clears the queue, the sequencer and the output stage.
// A stalled rsp side holds its beat and pauses the converter; req keeps
// being taken until the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii
   import itra_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // fields from bit 0: value, radix, zero fill
   input  logic [((VALUE_WIDTH + RADIX_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // fields from bit 0: out_char
   output logic [7:0]                                      rsp_tdata,
   output logic                                            rsp_tlast
);

   localparam int META_W = $bits(conv_meta_type);
   localparam int QW     = VALUE_WIDTH + META_W;

   logic                   push;
   logic [VALUE_WIDTH-1:0] push_mag;
   conv_meta_type          push_meta;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   pop;
   logic [QW-1:0]          pop_word;
   conv_meta_type          pop_meta;

   // input decode and classification
   itra_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .radix     (req_tdata[VALUE_WIDTH+RADIX_W-1:VALUE_WIDTH]),
      .queue_full(queue_full),
      .push      (push),
      .push_mag  (push_mag),
      .push_meta (push_meta)
   );

   // queue between front end and converter
   itra_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_meta, push_mag}),
      .full     (queue_full),
      .pop      (pop),
      .pop_data (pop_word),
      .empty    (queue_empty)
   );

   assign pop_meta = pop_word[QW-1 -: META_W];

   // conversion and character output
   itra_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (queue_empty),
      .q_mag    (pop_word[VALUE_WIDTH-1:0]),
      .q_meta   (pop_meta),
      .pop      (pop),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_char (rsp_tdata),
      .rsp_last (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/itra_front.sv @@
// ---------------------------------------------------------------------------
// itra_front
// Input side: takes request beats, decodes the radix, drops unsupported
// radices and forms the magnitude to convert.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itra_front
   import itra_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [VALUE_WIDTH-1:0] value,
   input  logic [RADIX_W-1:0]     radix,
   input  logic                   queue_full,
   output logic                   push,
   output logic [VALUE_WIDTH-1:0] push_mag,
   output conv_meta_type          push_meta
);

   radix_kind_type kind;
   logic           supported;

   // radix decode
   always_comb begin
      kind      = RADIX_BIN;
      supported = 1'b1;
      case (radix)
         RADIX_CODE_BIN: kind = RADIX_BIN;
         RADIX_CODE_OCT: kind = RADIX_OCT;
         RADIX_CODE_DEC: kind = RADIX_DEC;
         RADIX_CODE_HEX: kind = RADIX_HEX;
         default:        supported = 1'b0;
      endcase
   end

   // unsupported beats are taken and dropped
   assign in_ready = !queue_full;
   assign push     = in_valid && !queue_full && supported;

   // only decimal shows a sign; the rest convert the raw pattern
   assign push_meta.kind     = kind;
   assign push_meta.negative = (kind == RADIX_DEC) && value[VALUE_WIDTH-1];
   assign push_mag = push_meta.negative ? (~value + VALUE_WIDTH'(1)) : value;

endmodule

`default_nettype wire

@@ rtl/itra_queue.sv @@
// ---------------------------------------------------------------------------
// itra_queue
// Two-entry queue between the front end and the converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_ascii_assert.svh"

module itra_queue #(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ITRA_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ITRA_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)
   `ITRA_ASSERT_NEXT(a_push_counts, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire

@@ rtl/itra_back.sv @@
// ---------------------------------------------------------------------------
// itra_back
// Converter: takes one queued item, builds its digit string (bit-serial
// binary to bcd for decimal), skips leading zeros and sends prefix, sign
// and digits through a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_ascii_assert.svh"

module itra_back
   import itra_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [VALUE_WIDTH-1:0] q_mag,
   input  conv_meta_type          q_meta,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_char,
   output logic                   rsp_last
);

   // digit counts per radix
   localparam int ND_BIN = VALUE_WIDTH;
   localparam int ND_OCT = (VALUE_WIDTH + 2) / 3;
   localparam int ND_HEX = (VALUE_WIDTH + 3) / 4;
   localparam int ND_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W  = 4 * ND_DEC;
   localparam int OCT_W  = 3 * ND_OCT;
   localparam int HEX_W  = 4 * ND_HEX;
   localparam int WIDE_W = (BCD_W > HEX_W) ? BCD_W : HEX_W;
   localparam int WORK_W = (WIDE_W > OCT_W) ? WIDE_W : OCT_W;
   localparam int SH_BIN = WORK_W - VALUE_WIDTH;
   localparam int SH_OCT = WORK_W - OCT_W;
   localparam int SH_HEX = WORK_W - HEX_W;
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CONV = 6'b000010,
      S_SKIP = 6'b000100,
      S_PFX0 = 6'b001000,
      S_PFX1 = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   radix_kind_type         kind_ff, kind_in;
   logic                   neg_ff, neg_in;
   logic [WORK_W-1:0]      work_ff, work_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   slot_free;
   logic                   beat_load;
   logic [WORK_W-1:0]      load_pow2;
   logic [CNT_W-1:0]       nd_pow2;
   logic [BCD_W-1:0]       bcd_adj;
   logic [WORK_W-1:0]      work_conv;
   logic [3:0]             top_digit;
   logic [WORK_W-1:0]      work_shift;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // left-aligned digit string for the power-of-two radices
   always_comb begin
      case (q_meta.kind)
         RADIX_BIN: begin
            load_pow2 = WORK_W'(q_mag) << SH_BIN;
            nd_pow2   = CNT_W'(ND_BIN);
         end
         RADIX_OCT: begin
            load_pow2 = WORK_W'(q_mag) << SH_OCT;
            nd_pow2   = CNT_W'(ND_OCT);
         end
         default: begin
            load_pow2 = WORK_W'(q_mag) << SH_HEX;
            nd_pow2   = CNT_W'(ND_HEX);
         end
      endcase
   end

   // one double-dabble step: add three to each bcd digit above four, shift in
   always_comb begin
      for (int i = 0; i < ND_DEC; i++) begin
         if (work_ff[WORK_W-1-4*i -: 4] > 4'd4) begin
            bcd_adj[BCD_W-1-4*i -: 4] = work_ff[WORK_W-1-4*i -: 4] + 4'd3;
         end else begin
            bcd_adj[BCD_W-1-4*i -: 4] = work_ff[WORK_W-1-4*i -: 4];
         end
      end
      work_conv = '0;
      work_conv[WORK_W-1 -: BCD_W] = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
   end

   // leading digit and digit shift by radix
   always_comb begin
      case (kind_ff)
         RADIX_BIN: begin
            top_digit  = {3'b000, work_ff[WORK_W-1]};
            work_shift = work_ff << 1;
         end
         RADIX_OCT: begin
            top_digit  = {1'b0, work_ff[WORK_W-1 -: 3]};
            work_shift = work_ff << 3;
         end
         default: begin
            top_digit  = work_ff[WORK_W-1 -: 4];
            work_shift = work_ff << 4;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      neg_in      = neg_ff;
      work_in     = work_ff;
      bin_in      = bin_ff;
      cnt_in      = cnt_ff;
      pop         = 1'b0;
      beat_load   = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               kind_in = q_meta.kind;
               neg_in  = q_meta.negative;
               if (q_meta.kind == RADIX_DEC) begin
                  work_in  = '0;
                  bin_in   = q_mag;
                  cnt_in   = CNT_W'(VALUE_WIDTH);
                  state_in = S_CONV;
               end else begin
                  work_in  = load_pow2;
                  cnt_in   = nd_pow2;
                  state_in = S_SKIP;
               end
            end
         end
         S_CONV: begin
            work_in = work_conv;
            bin_in  = bin_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = CNT_W'(ND_DEC);
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (cnt_ff > CNT_W'(1) && top_digit == 4'd0) begin
               work_in = work_shift;
               cnt_in  = cnt_ff - CNT_W'(1);
            end else if (kind_ff == RADIX_DEC && !neg_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_PFX0;
            end
         end
         S_PFX0: begin
            if (slot_free) begin
               beat_load   = 1'b1;
               rsp_char_in = (kind_ff == RADIX_DEC) ? CHAR_MINUS : CHAR_ZERO;
               if (kind_ff == RADIX_BIN || kind_ff == RADIX_HEX) begin
                  state_in = S_PFX1;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_PFX1: begin
            if (slot_free) begin
               beat_load   = 1'b1;
               rsp_char_in = (kind_ff == RADIX_HEX) ? CHAR_X : CHAR_B;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               beat_load   = 1'b1;
               rsp_char_in = digit_glyph(top_digit);
               rsp_last_in = (cnt_ff == CNT_W'(1));
               work_in     = work_shift;
               cnt_in      = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output stage valid
   assign rsp_valid_in = beat_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and output payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      neg_ff  <= neg_in;
      work_ff <= work_in;
      bin_ff  <= bin_in;
      cnt_ff  <= cnt_in;
      if (beat_load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

   `ITRA_ASSERT_NEXT(a_last_ends_item, clock, reset, beat_load && rsp_last_in, state_ff == S_IDLE)
   `ITRA_ASSERT_NEVER(a_emit_has_digit, clock, reset, (state_ff == S_EMIT) && (cnt_ff == '0))

endmodule

`default_nettype wire
